/* rtl/core/keypad_code_lock_core_defines.svh */
// ----------------------------------------------------------------------------
// Keypad code lock assertion macros
// Shared assertion macros for the keypad code lock core. Each one is clocked
// on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_CODE_LOCK_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CORE_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define KCL_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// When the antecedent holds, the consequent must hold at the same edge.
`define KCL_ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* rtl/core/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// Keypad code lock package
// Constants, codes and types shared by the keypad code lock modules.
// ----------------------------------------------------------------------------
package kcl_pkg;

	localparam int CODE_LENGTH = 7;
	localparam int TIMER_BITS = 20;

	localparam int CFG_W = 20;
	localparam int DIGIT_W = 4;
	localparam int OUT_DIGITS = 7;
	localparam int STORED_W = OUT_DIGITS * DIGIT_W;
	localparam int CNT_W = $clog2(CODE_LENGTH + 1);
	localparam int DIG_OUT_W = 3;
	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	localparam logic [CFG_W-1:0] CFG_RESET_TICKS = CFG_W'(5000);
	localparam logic [DIGIT_W-1:0] KEY_CMD_FIRST = DIGIT_W'(10);
	localparam logic [DIGIT_W-1:0] KEY_CMD_LAST = DIGIT_W'(13);

	typedef logic [DIGIT_W-1:0] digit_t;
	typedef logic [TIMER_BITS-1:0] tmr_t;

	typedef enum logic [1:0] {
		OP_KEY  = 2'd0,
		OP_PROG = 2'd1,
		OP_TICK = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		OUTC_NONE   = 2'd0,
		OUTC_ACCEPT = 2'd1,
		OUTC_REJECT = 2'd2,
		OUTC_STORED = 2'd3
	} outcome_t;

	typedef enum logic {
		CFG_CLEAR_TIMEOUT = 1'b0,
		CFG_UNLOCK_HOLD   = 1'b1
	} cfg_idx_t;

	// Control that every digit cell sees in the same cycle.
	typedef struct packed {
		logic shift_en;
		logic load_code;
	} cell_ctrl_t;

	typedef struct packed {
		outcome_t outcome;
		logic unlocked;
		logic in_program_mode;
		logic [DIG_OUT_W-1:0] digits_entered;
		logic echo_valid;
		logic echo_masked;
		digit_t echo_digit;
		logic entry_cleared;
		logic [STORED_W-1:0] stored_code;
	} result_t;

endpackage

/* rtl/core/keypad_code_lock_core.sv */
// ----------------------------------------------------------------------------
// Keypad code lock core
// Collects keypad digits, checks them against a stored code, opens the lock
// for a hold time and lets a new code be programmed.
// ----------------------------------------------------------------------------
// Usage: each input beat (in_valid/in_ready) carries one item: a keypad
// sample, a program-button event or a time tick. Every accepted beat yields
// exactly one result beat (out_valid/out_ready) holding the outcome and the
// status after that item. Two timeout registers are written through the
// cfg_we/cfg_index/cfg_wdata port; the user must write them only while the
// block is idle, which the block does not enforce. Each result is held in
// the output register, or in the skid register behind it while that one is
// full. Throughput is one item per cycle while in_ready is high, set by the
// single update of the control registers and the digit chain per accepted
// beat. A stalled receiver does not stall the input until both are full;
// in_ready then drops and comes back in the cycle after the receiver takes
// a beat. Reset clears the stored code to all zeros, closes the lock, leaves
// program mode, empties the entry and sets both timeouts to 5000 ticks.
// ----------------------------------------------------------------------------
`include "keypad_code_lock_core_defines.svh"

module keypad_code_lock_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [kcl_pkg::CFG_W-1:0]     cfg_wdata,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    opcode,
	input  logic                          key_down,
	input  logic [3:0]                    key_value,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [1:0]                    outcome,
	output logic                          unlocked,
	output logic                          in_program_mode,
	output logic [2:0]                    digits_entered,
	output logic                          echo_valid,
	output logic                          echo_masked,
	output logic [3:0]                    echo_digit,
	output logic                          entry_cleared,
	output logic [kcl_pkg::STORED_W-1:0]  stored_code_out
);
	import kcl_pkg::*;

	localparam tmr_t TMR_MAX = '1;
	localparam tmr_t TMR_ONE = TIMER_BITS'(1);

	// Saturating tick counter increment.
	function automatic tmr_t bump(input tmr_t c);
		return (c == TMR_MAX) ? c : c + TMR_ONE;
	endfunction

	// Configuration registers.
	logic [CFG_W-1:0] clear_timeout_q;
	logic [CFG_W-1:0] unlock_hold_q;

	// Control state.
	logic [CNT_W-1:0] entry_count_q, entry_count_d;
	logic key_was_down_q, key_was_down_d;
	logic program_mode_q, program_mode_d;
	logic open_q, open_d;
	tmr_t hold_q, hold_d;
	tmr_t idle_q, idle_d;
	logic idle_run_q, idle_run_d;

	logic accept;
	op_t op;
	logic is_cmd_key;
	tmr_t hold_inc;
	tmr_t idle_inc;
	cell_ctrl_t ctrl_raw;
	cell_ctrl_t cell_ctrl;
	result_t res_d;
	result_t res_q;

	// Digit chain wiring. Cell CODE_LENGTH-1 takes the key; every other cell
	// takes its upper neighbor's entry, so after a full entry cell 0 holds
	// the first digit typed.
	digit_t entry_vec [CODE_LENGTH];
	digit_t shift_vec [CODE_LENGTH];
	digit_t code_vec [CODE_LENGTH];
	logic match_vec [CODE_LENGTH+1];
	logic [STORED_W-1:0] stored_packed;

	assign accept = in_valid && in_ready;
	assign op = op_t'(opcode);
	assign is_cmd_key = (key_value >= KEY_CMD_FIRST) && (key_value <= KEY_CMD_LAST);
	assign hold_inc = bump(hold_q);
	assign idle_inc = bump(idle_q);
	assign match_vec[0] = 1'b1;

	genvar gi;
	generate
		for (gi = 0; gi < CODE_LENGTH; gi++) begin : g_cell
			if (gi == CODE_LENGTH - 1) begin : g_top
				assign shift_vec[gi] = key_value;
			end else begin : g_mid
				assign shift_vec[gi] = entry_vec[gi+1];
			end

			kcl_digit_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (cell_ctrl),
				.shift_in  (shift_vec[gi]),
				.match_in  (match_vec[gi]),
				.entry_q   (entry_vec[gi]),
				.match_out (match_vec[gi+1]),
				.code_nxt  (code_vec[gi])
			);
		end

		// Only the first seven digits of the code fit the status field.
		for (gi = 0; gi < OUT_DIGITS; gi++) begin : g_pack
			if (gi < CODE_LENGTH) begin : g_used
				assign stored_packed[gi*DIGIT_W +: DIGIT_W] = code_vec[gi];
			end else begin : g_pad
				assign stored_packed[gi*DIGIT_W +: DIGIT_W] = '0;
			end
		end
	endgenerate

	// Next-state logic for one item. This state moves only on an accepted beat.
	always_comb begin
		entry_count_d = entry_count_q;
		key_was_down_d = key_was_down_q;
		program_mode_d = program_mode_q;
		open_d = open_q;
		hold_d = hold_q;
		idle_d = idle_q;
		idle_run_d = idle_run_q;
		ctrl_raw = '0;
		res_d = '0;
		res_d.outcome = OUTC_NONE;

		case (op)
			OP_KEY: begin
				if (!key_down) begin
					key_was_down_d = 1'b0;
				end else begin
					// Any held key restarts the idle timer outside program mode.
					if (!program_mode_q) begin
						idle_d = '0;
						idle_run_d = 1'b1;
					end
					// A new press of a digit key; command keys leave the
					// press flag alone so a following digit still counts.
					if (!key_was_down_q && !is_cmd_key) begin
						ctrl_raw.shift_en = 1'b1;
						key_was_down_d = 1'b1;
						res_d.echo_valid = 1'b1;
						res_d.echo_masked = !program_mode_q;
						res_d.echo_digit = key_value;
						if (entry_count_q == CNT_W'(CODE_LENGTH - 1)) begin
							entry_count_d = '0;
							if (program_mode_q) begin
								ctrl_raw.load_code = 1'b1;
								program_mode_d = 1'b0;
								res_d.outcome = OUTC_STORED;
							end else if (match_vec[CODE_LENGTH]) begin
								// A correct code while open restarts the hold.
								open_d = 1'b1;
								hold_d = '0;
								res_d.outcome = OUTC_ACCEPT;
							end else begin
								res_d.outcome = OUTC_REJECT;
							end
						end else begin
							entry_count_d = entry_count_q + CNT_W'(1);
						end
					end
				end
			end
			OP_PROG: begin
				if (!program_mode_q) begin
					program_mode_d = 1'b1;
					entry_count_d = '0;
					idle_run_d = 1'b0;
					idle_d = '0;
				end
			end
			OP_TICK: begin
				if (open_q) begin
					if (CMP_W'(hold_inc) >= CMP_W'(unlock_hold_q)) begin
						open_d = 1'b0;
						hold_d = '0;
					end else begin
						hold_d = hold_inc;
					end
				end
				// The idle timer is one-shot: it stops when it expires.
				if (idle_run_q && !program_mode_q) begin
					if (CMP_W'(idle_inc) >= CMP_W'(clear_timeout_q)) begin
						idle_run_d = 1'b0;
						idle_d = '0;
						if (entry_count_q != '0) begin
							entry_count_d = '0;
							res_d.entry_cleared = 1'b1;
						end
					end else begin
						idle_d = idle_inc;
					end
				end
			end
			default: begin
				// Opcode three only reports status.
			end
		endcase

		res_d.unlocked = open_d;
		res_d.in_program_mode = program_mode_d;
		res_d.digits_entered = DIG_OUT_W'(entry_count_d);
		res_d.stored_code = stored_packed;
	end

	assign cell_ctrl = accept ? ctrl_raw : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_timeout_q <= CFG_RESET_TICKS;
			unlock_hold_q <= CFG_RESET_TICKS;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_CLEAR_TIMEOUT: clear_timeout_q <= cfg_wdata;
				CFG_UNLOCK_HOLD: unlock_hold_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			key_was_down_q <= 1'b0;
			program_mode_q <= 1'b0;
			open_q <= 1'b0;
			hold_q <= '0;
			idle_q <= '0;
			idle_run_q <= 1'b0;
		end else if (accept) begin
			entry_count_q <= entry_count_d;
			key_was_down_q <= key_was_down_d;
			program_mode_q <= program_mode_d;
			open_q <= open_d;
			hold_q <= hold_d;
			idle_q <= idle_d;
			idle_run_q <= idle_run_d;
		end
	end

	kcl_result_buf u_result_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_d),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head_q    (res_q)
	);

	assign outcome = res_q.outcome;
	assign unlocked = res_q.unlocked;
	assign in_program_mode = res_q.in_program_mode;
	assign digits_entered = res_q.digits_entered;
	assign echo_valid = res_q.echo_valid;
	assign echo_masked = res_q.echo_masked;
	assign echo_digit = res_q.echo_digit;
	assign entry_cleared = res_q.entry_cleared;
	assign stored_code_out = res_q.stored_code;

	// The skid register only fills behind a full output register.
	`KCL_ASSERT_IMPLY(a_skid_behind_head, !in_ready, out_valid, "skid full with output empty")
	// An accepted code always leaves the lock open in the same result.
	`KCL_ASSERT_IMPLY(a_accept_opens, out_valid && (outcome == OUTC_ACCEPT), unlocked, "accepted code but lock closed")
	// Storing a code ends program mode and empties the entry.
	`KCL_ASSERT_IMPLY(a_store_exits, out_valid && (outcome == OUTC_STORED), !in_program_mode && (digits_entered == '0), "code stored but entry or mode left over")
	// Program mode keeps the idle timer stopped.
	`KCL_ASSERT_ALWAYS(a_idle_stopped, !(program_mode_q && idle_run_q), "idle timer running in program mode")

endmodule

/* rtl/core/kcl_digit_cell.sv */
// ----------------------------------------------------------------------------
// Keypad code lock digit cell
// One position of the code: the entered digit, the stored digit and one link
// of the match chain.
// ----------------------------------------------------------------------------
module kcl_digit_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  kcl_pkg::cell_ctrl_t ctrl,
	input  kcl_pkg::digit_t    shift_in,
	input  logic               match_in,
	output kcl_pkg::digit_t    entry_q,
	output logic               match_out,
	output kcl_pkg::digit_t    code_nxt
);
	import kcl_pkg::*;

	digit_t code_q;

	// The digit arriving from the neighbor is this position's digit once the
	// current key has been shifted in, so it is what gets compared or stored.
	assign match_out = match_in && (shift_in == code_q);
	assign code_nxt = ctrl.load_code ? shift_in : code_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift_en) begin
			entry_q <= shift_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= '0;
		end else begin
			code_q <= code_nxt;
		end
	end

endmodule

/* rtl/core/kcl_result_buf.sv */
// ----------------------------------------------------------------------------
// Keypad code lock result buffer
// Two-entry output buffer: an output register and a skid register, so the
// input side keeps taking beats while a result waits.
// ----------------------------------------------------------------------------
module kcl_result_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kcl_pkg::result_t push_data,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output kcl_pkg::result_t head_q
);
	import kcl_pkg::*;

	result_t skid_q;
	logic head_v_q;
	logic skid_v_q;
	logic pop;
	logic head_load;

	assign pop = head_v_q && out_ready;
	assign head_load = !head_v_q || pop;
	assign in_ready = !skid_v_q;
	assign out_valid = head_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (head_load) begin
			head_v_q <= skid_v_q || push;
			skid_v_q <= 1'b0;
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (head_load) begin
			head_q <= skid_v_q ? skid_q : push_data;
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

/* tb/sv/lock_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code lock scoreboard
// Tracks lock state, entry and stored code from the beats taken by the core,
// predicts the status that each beat returns and checks results in order.
// ----------------------------------------------------------------------------
package lock_tb_pkg;

	import kcl_pkg::*;

	localparam int unsigned SHOW_LIMIT = 100;

	class lock_scoreboard;

		digit_t code_q [CODE_LENGTH];
		digit_t entry_q [CODE_LENGTH];
		int unsigned entry_count;
		bit key_held;
		bit prog_mode;
		bit open_now;
		bit idle_on;
		tmr_t hold_ticks;
		tmr_t idle_ticks;
		logic [CFG_W-1:0] clear_limit;
		logic [CFG_W-1:0] hold_limit;

		result_t expected_status [$];
		int unsigned beats_checked;
		int unsigned mismatches;

		function new();
			foreach (code_q[i]) begin
				code_q[i] = '0;
				entry_q[i] = '0;
			end
			entry_count = 0;
			key_held = 1'b0;
			prog_mode = 1'b0;
			open_now = 1'b0;
			idle_on = 1'b0;
			hold_ticks = '0;
			idle_ticks = '0;
			clear_limit = CFG_RESET_TICKS;
			hold_limit = CFG_RESET_TICKS;
			beats_checked = 0;
			mismatches = 0;
		endfunction

		function void set_limit(cfg_idx_t idx, logic [CFG_W-1:0] ticks);
			if (idx == CFG_CLEAR_TIMEOUT) begin
				clear_limit = ticks;
			end else begin
				hold_limit = ticks;
			end
		endfunction

		function int unsigned pending();
			return expected_status.size();
		endfunction

		function logic [STORED_W-1:0] stored_code();
			logic [STORED_W-1:0] packed_code;
			packed_code = '0;
			for (int i = 0; i < OUT_DIGITS && i < CODE_LENGTH; i++) begin
				packed_code[DIGIT_W*i +: DIGIT_W] = code_q[i];
			end
			return packed_code;
		endfunction

		// Timers stick at their top value instead of wrapping.
		function tmr_t bump(tmr_t c);
			return (c == '1) ? c : c + 1'b1;
		endfunction

		function result_t predict_status(op_t op, logic down, digit_t key);
			result_t r;
			bit full_match;
			bit cleared;
			r = '0;
			cleared = 1'b0;
			case (op)
				OP_KEY: begin
					if (!down) begin
						key_held = 1'b0;
					end else begin
						if (!prog_mode) begin
							idle_ticks = '0;
							idle_on = 1'b1;
						end
						// Command keys never mark the key as held, so a digit that follows
						// without a release still counts.
						if (!key_held && !(key >= KEY_CMD_FIRST && key <= KEY_CMD_LAST)) begin
							entry_q[entry_count] = key;
							entry_count++;
							r.echo_valid = 1'b1;
							r.echo_masked = !prog_mode;
							r.echo_digit = key;
							if (entry_count >= CODE_LENGTH) begin
								if (prog_mode) begin
									code_q = entry_q;
									prog_mode = 1'b0;
									r.outcome = OUTC_STORED;
								end else begin
									full_match = 1'b1;
									foreach (code_q[i]) begin
										if (code_q[i] != entry_q[i]) full_match = 1'b0;
									end
									if (full_match) begin
										open_now = 1'b1;
										hold_ticks = '0;
										r.outcome = OUTC_ACCEPT;
									end else begin
										r.outcome = OUTC_REJECT;
									end
								end
								entry_count = 0;
							end
							key_held = 1'b1;
						end
					end
				end
				OP_PROG: begin
					if (!prog_mode) begin
						prog_mode = 1'b1;
						entry_count = 0;
						idle_on = 1'b0;
						idle_ticks = '0;
					end
				end
				OP_TICK: begin
					if (open_now) begin
						hold_ticks = bump(hold_ticks);
						if (hold_ticks >= hold_limit) begin
							open_now = 1'b0;
							hold_ticks = '0;
						end
					end
					if (idle_on && !prog_mode) begin
						idle_ticks = bump(idle_ticks);
						if (idle_ticks >= clear_limit) begin
							idle_on = 1'b0;
							idle_ticks = '0;
							if (entry_count != 0) begin
								entry_count = 0;
								cleared = 1'b1;
							end
						end
					end
				end
				default: begin
				end
			endcase
			r.unlocked = open_now;
			r.in_program_mode = prog_mode;
			r.digits_entered = entry_count[DIG_OUT_W-1:0];
			r.entry_cleared = cleared;
			r.stored_code = stored_code();
			return r;
		endfunction

		function void note_item(op_t op, logic down, digit_t key);
			expected_status.push_back(predict_status(op, down, key));
		endfunction

		task report(string msg);
			mismatches++;
			if (mismatches <= SHOW_LIMIT) $display("MISMATCH %s", msg);
		endtask

		task check_field(string name, logic [STORED_W-1:0] got, logic [STORED_W-1:0] want);
			if (got !== want) begin
				report($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
					beats_checked, name, got, want));
			end
		endtask

		task check_status(result_t got);
			result_t want;
			beats_checked++;
			if (expected_status.size() == 0) begin
				report($sformatf("beat %0d: result with nothing expected", beats_checked));
				return;
			end
			want = expected_status.pop_front();
			check_field("outcome", STORED_W'(got.outcome), STORED_W'(want.outcome));
			check_field("unlocked", STORED_W'(got.unlocked), STORED_W'(want.unlocked));
			check_field("in_program_mode", STORED_W'(got.in_program_mode),
				STORED_W'(want.in_program_mode));
			check_field("digits_entered", STORED_W'(got.digits_entered),
				STORED_W'(want.digits_entered));
			check_field("echo_valid", STORED_W'(got.echo_valid), STORED_W'(want.echo_valid));
			check_field("echo_masked", STORED_W'(got.echo_masked), STORED_W'(want.echo_masked));
			check_field("echo_digit", STORED_W'(got.echo_digit), STORED_W'(want.echo_digit));
			check_field("entry_cleared", STORED_W'(got.entry_cleared),
				STORED_W'(want.entry_cleared));
			check_field("stored_code_out", got.stored_code, want.stored_code);
		endtask

	endclass

endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code lock core testbench
// Drives keypad samples, program presses and ticks into the core, predicts
// every status beat and checks it in order. A short directed run covers key
// handling, code match, programming and ticks under the reset timeouts;
// random phases then sweep both timeout registers from zero to their top value.
// ----------------------------------------------------------------------------
module testbench;

	import kcl_pkg::*;
	import lock_tb_pkg::*;

	// The slowest legal run is roughly 1700 beats, each behind the longest send
	// gap plus the long sink stall; the limit leaves several times that.
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PHASES = 6;
	localparam int unsigned ITEMS_PER_PHASE = 260;
	localparam int unsigned LONG_STALL_PHASE = 3;
	localparam int unsigned LONG_STALL_CYCLES = 80;
	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DIRECTED_TICKS = 20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = CFG_CLEAR_TIMEOUT;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] opcode = OP_NOP;
	logic key_down = 1'b0;
	logic [3:0] key_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] outcome;
	logic unlocked;
	logic in_program_mode;
	logic [2:0] digits_entered;
	logic echo_valid;
	logic echo_masked;
	logic [3:0] echo_digit;
	logic entry_cleared;
	logic [STORED_W-1:0] stored_code_out;

	result_t seen_status;

	bit send_gaps_on = 1'b1;
	bit sink_stalls_on = 1'b1;
	bit long_stall_req = 1'b0;
	int unsigned items_sent = 0;
	int unsigned cycle_count = 0;

	lock_scoreboard lock_sb = new();

	keypad_code_lock_core i_dut (.*);

	always #2 clk = ~clk;

	assign seen_status = {outcome, unlocked, in_program_mode, digits_entered, echo_valid,
		echo_masked, echo_digit, entry_cleared, stored_code_out};

	// Outputs are read at the rising edge, before the core updates them.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) lock_sb.check_status(seen_status);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// Mostly back-to-back, sometimes a short pause and now and then a long one.
	function automatic int unsigned pick_gap(bit enabled);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 70) return 0;
		if (r < 96) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result sink. The long hold-off is counted here so that the sender keeps
	// offering beats while the output and skid registers fill and in_ready
	// drops.
	initial begin : result_sink
		int unsigned stall;
		stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_stall_req) begin
				long_stall_req = 1'b0;
				stall = LONG_STALL_CYCLES;
			end else if (stall == 0) begin
				stall = pick_gap(sink_stalls_on);
			end
			if (stall != 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// One input beat. Valid rises after an optional gap and holds until the
	// core takes the beat; the scoreboard sees the beat on the accepting edge.
	task automatic send_item(op_t op, logic down, digit_t key);
		int unsigned gap;
		gap = pick_gap(send_gaps_on);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opcode <= op;
		key_down <= down;
		key_value <= key;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
		lock_sb.note_item(op, down, key);
	endtask

	// Drop valid and wait until every predicted status beat has come back.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (lock_sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(cfg_idx_t idx, logic [CFG_W-1:0] ticks);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= ticks;
		@(negedge clk);
		cfg_we <= 1'b0;
		lock_sb.set_limit(idx, ticks);
	endtask

	function automatic digit_t any_code_digit();
		int unsigned v;
		v = $urandom_range(0, 11);
		return (v >= 10) ? digit_t'(v + 4) : digit_t'(v);
	endfunction

	// A key press with its release, sometimes preceded by a command key,
	// sometimes held over several samples or interrupted by a tick.
	task automatic type_digit(digit_t d);
		if ($urandom_range(0, 9) == 0)
			send_item(OP_KEY, 1'b1, digit_t'($urandom_range(KEY_CMD_FIRST, KEY_CMD_LAST)));
		send_item(OP_KEY, 1'b1, d);
		if ($urandom_range(0, 4) == 0) send_item(OP_KEY, 1'b1, digit_t'($urandom_range(0, 15)));
		if ($urandom_range(0, 15) == 0) send_item(OP_TICK, 1'b0, d);
		send_item(OP_KEY, 1'b0, digit_t'($urandom_range(0, 15)));
	endtask

	task automatic type_digits(logic [STORED_W-1:0] digits, int unsigned count);
		for (int unsigned i = 0; i < count; i++) begin
			type_digit(digits[DIGIT_W*i +: DIGIT_W]);
		end
	endtask

	// Up to enough ticks to run one of the timers out when it is short.
	task automatic tick_burst();
		int unsigned span;
		span = 32'($urandom_range(0, 1) ? lock_sb.clear_limit : lock_sb.hold_limit);
		if (span > 60) span = 60;
		repeat ($urandom_range(1, span + 2))
			send_item(OP_TICK, 1'($urandom_range(0, 1)), digit_t'($urandom_range(0, 15)));
	endtask

	// Mostly well-formed code entries with random content, some programming,
	// partial entries left to time out, tick runs and a little noise.
	task automatic random_sequence();
		logic [STORED_W-1:0] digits;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		for (int i = 0; i < CODE_LENGTH; i++) digits[DIGIT_W*i +: DIGIT_W] = any_code_digit();
		if (pick < 30) begin
			type_digits(lock_sb.stored_code(), CODE_LENGTH);
		end else if (pick < 42) begin
			type_digits(digits, CODE_LENGTH);
		end else if (pick < 48) begin
			digits = lock_sb.stored_code();
			digits[DIGIT_W*$urandom_range(0, CODE_LENGTH - 1) +: DIGIT_W] = any_code_digit();
			type_digits(digits, CODE_LENGTH);
		end else if (pick < 58) begin
			send_item(OP_PROG, 1'($urandom_range(0, 1)), digit_t'($urandom_range(0, 15)));
			if ($urandom_range(0, 3) == 0) send_item(OP_PROG, 1'b0, '0);
			type_digits(digits, CODE_LENGTH);
		end else if (pick < 72) begin
			if ($urandom_range(0, 3) == 0) send_item(OP_PROG, 1'b0, '0);
			type_digits(digits, $urandom_range(1, CODE_LENGTH - 1));
			tick_burst();
		end else if (pick < 86) begin
			tick_burst();
		end else begin
			repeat ($urandom_range(1, 6))
				send_item(op_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					digit_t'($urandom_range(0, 15)));
		end
	endtask

	initial begin : stimulus
		logic [CFG_W-1:0] clear_ticks;
		logic [CFG_W-1:0] hold_ticks;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part, at the reset timeouts. A NOP with every payload bit
		// set, a release, then a command key followed straight away by a digit.
		send_item(OP_NOP, 1'b1, 4'hF);
		send_item(OP_KEY, 1'b0, 4'hF);
		send_item(OP_KEY, 1'b1, KEY_CMD_LAST);
		send_item(OP_KEY, 1'b1, 4'h0);
		send_item(OP_KEY, 1'b1, 4'h0);
		// Six more zeros complete the all-zero code that reset leaves behind.
		repeat (CODE_LENGTH - 1) begin
			send_item(OP_KEY, 1'b0, 4'h0);
			send_item(OP_KEY, 1'b1, 4'h0);
		end
		send_item(OP_KEY, 1'b0, 4'h0);
		// A second program press is ignored; digits now echo unmasked, and a
		// tick moves the hold timer but not the idle timer.
		send_item(OP_PROG, 1'b0, 4'h0);
		send_item(OP_PROG, 1'b1, 4'hF);
		send_item(OP_KEY, 1'b1, 4'hF);
		send_item(OP_KEY, 1'b0, 4'h0);
		send_item(OP_KEY, 1'b1, 4'hE);
		send_item(OP_KEY, 1'b0, 4'h0);
		send_item(OP_TICK, 1'b1, 4'hA);
		type_digits(28'h0054321, 5);
		// A partial entry, then a short run of ticks well inside both reset
		// timeouts, so the entry and the open lock survive it.
		type_digits(28'h9, 1);
		repeat (DIRECTED_TICKS)
			send_item(OP_TICK, 1'($urandom_range(0, 1)), digit_t'($urandom_range(0, 15)));
		drain_results();

		for (int unsigned p = 0; p < PHASES; p++) begin
			case (p)
				0: begin
					clear_ticks = CFG_W'(12);
					hold_ticks = CFG_W'(30);
				end
				1: begin
					clear_ticks = CFG_W'(1);
					hold_ticks = CFG_W'(1);
				end
				2: begin
					clear_ticks = '0;
					hold_ticks = '0;
				end
				3: begin
					clear_ticks = CFG_W'(45);
					hold_ticks = CFG_W'(4);
				end
				4: begin
					clear_ticks = '1;
					hold_ticks = '1;
				end
				default: begin
					clear_ticks = CFG_W'($urandom_range(2, 60));
					hold_ticks = CFG_W'($urandom_range(2, 200));
				end
			endcase
			write_limit(CFG_CLEAR_TIMEOUT, clear_ticks);
			write_limit(CFG_UNLOCK_HOLD, hold_ticks);
			if (p == LONG_STALL_PHASE) begin
				send_gaps_on = 1'b0;
				sink_stalls_on = 1'b1;
				long_stall_req = 1'b1;
			end else begin
				send_gaps_on = ($urandom_range(0, 3) != 0);
				sink_stalls_on = ($urandom_range(0, 3) != 0);
			end
			items_sent = 0;
			while (items_sent < ITEMS_PER_PHASE) random_sequence();
			drain_results();
		end

		if (lock_sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
